// File: rtl/core/acv_pkg.sv
// ----------------------------------------------------------------------------
// acv_pkg - shared types and constants for the CORDIC arctangent core
// Field widths, angle format, the atan(2^-k) table and pipeline control.
// ----------------------------------------------------------------------------
`default_nettype none

package acv_pkg;

  localparam int TAN_W     = 32;         // Q16.16 input
  localparam int ANG_W     = 30;         // Q2.28 output
  localparam int Z_W       = 35;         // Q.32 angle accumulator, |z| < 2^33
  localparam int ROM_DEPTH = 30;

  localparam logic signed [Z_W-1:0] HALF_PI_Q28 = 35'sd421657428;

  // control travelling alongside each pipeline slot
  typedef struct packed {
    logic valid;
    logic zero;   // input was exactly zero
  } ctl_t;

  // output buffer occupancy
  typedef struct packed {
    logic out_v;
    logic skid_v;
  } buf_stat_t;

  // atan(2^-k) * 2^32, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_rom(input int k);
    logic signed [Z_W-1:0] v;
    case (k)
      0:       v = 35'sd3373259426;
      1:       v = 35'sd1991351318;
      2:       v = 35'sd1052175346;
      3:       v = 35'sd534100635;
      4:       v = 35'sd268086748;
      5:       v = 35'sd134174063;
      6:       v = 35'sd67103403;
      7:       v = 35'sd33553749;
      8:       v = 35'sd16777131;
      9:       v = 35'sd8388597;
      10:      v = 35'sd4194303;
      default: v = (k < ROM_DEPTH) ? (35'sd1 <<< (32 - k)) : '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/acv_in_if.sv
// ----------------------------------------------------------------------------
// acv_in_if - tangent input channel
// Valid/ready stream carrying one Q16.16 tangent per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface acv_in_if
  import acv_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [TAN_W-1:0] tangent_in;

  modport source (output valid, output tangent_in, input ready);
  modport sink   (input valid, input tangent_in, output ready);
endinterface

`default_nettype wire

// File: rtl/core/acv_out_if.sv
// ----------------------------------------------------------------------------
// acv_out_if - angle result channel
// Valid/ready stream carrying one Q2.28 angle per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface acv_out_if
  import acv_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] angle_out;

  modport source (output valid, output angle_out, input ready);
  modport sink   (input valid, input angle_out, output ready);
endinterface

`default_nettype wire

// File: rtl/core/arctan_cordic_vectoring.sv
// ----------------------------------------------------------------------------
// arctan_cordic_vectoring - pipelined vectoring-mode CORDIC arctangent
// atan of a Q16.16 tangent, returned as a Q2.28 angle clamped to +/-pi/2.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                      | format
//   --------+-----+------------------------------+------------------
//   in_ch   | in  | tangent_in  [31:0] signed    | Q16.16 tangent
//   out_ch  | out | angle_out   [29:0] signed    | Q2.28 radians
//
// One transfer per cycle in and out while the skid entry is empty. Each result is
// registered in every cell of the rotation chain, then in the output register.
// Synchronous active-low reset clears all valid flags; data flops are
// not reset. A stalled output first fills a skid entry; the chain and
// in_ch.ready hold only while that entry is full.
// ----------------------------------------------------------------------------
`default_nettype none

module arctan_cordic_vectoring
  import acv_pkg::*;
#(
  parameter int ITERATIONS     = 23,
  parameter int INTERNAL_WIDTH = 48
) (
  input wire logic  clk,
  input wire logic  rst_n,
  acv_in_if.sink    in_ch,
  acv_out_if.source out_ch
);

  // number of rotation cells; the angle table stops at ROM_DEPTH
  localparam int NS = (ITERATIONS > ROM_DEPTH) ? ROM_DEPTH : ITERATIONS;
  localparam int W  = INTERNAL_WIDTH;
  // x, y carry W-19 fraction bits; the input has 16
  localparam int YSH = W - 35;

  logic en;

  // chain taps: index 0 is the seed from the input channel
  ctl_t                  ctl [NS+1];
  logic signed [W-1:0]   xs  [NS+1];
  logic signed [W-1:0]   ys  [NS+1];
  logic signed [Z_W-1:0] zs  [NS+1];

  assign in_ch.ready = en;

  // seed: x = 1.0, y = tangent widened with sign, z = 0
  assign ctl[0].valid = in_ch.valid;
  assign ctl[0].zero  = (in_ch.tangent_in == '0);
  assign xs[0]        = W'(1) <<< (W - 19);
  assign ys[0]        = {{3{in_ch.tangent_in[TAN_W-1]}}, in_ch.tangent_in, {YSH{1'b0}}};
  assign zs[0]        = '0;

  for (genvar k = 0; k < NS; k++) begin : g_cell
    acv_cell #(
      .W (W),
      .K (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl[k]),
      .x_i   (xs[k]),
      .y_i   (ys[k]),
      .z_i   (zs[k]),
      .ctl_o (ctl[k+1]),
      .x_o   (xs[k+1]),
      .y_o   (ys[k+1]),
      .z_o   (zs[k+1])
    );
  end

  // round Q.32 to Q.28 (add half an LSB, floor), then clamp to +/-pi/2; a zero input gives 0
  logic signed [Z_W-1:0]   z_rnd;
  logic signed [Z_W-1:0]   z_q28;
  logic signed [ANG_W-1:0] angle_res;

  always_comb begin
    z_rnd = zs[NS] + Z_W'(8);
    z_q28 = z_rnd >>> 4;
    if (ctl[NS].zero) begin
      angle_res = '0;
    end else if (z_q28 > HALF_PI_Q28) begin
      angle_res = HALF_PI_Q28[ANG_W-1:0];
    end else if (z_q28 < -HALF_PI_Q28) begin
      angle_res = ANG_W'(-HALF_PI_Q28);
    end else begin
      angle_res = z_q28[ANG_W-1:0];
    end
  end

  buf_stat_t bstat;

  acv_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (en && ctl[NS].valid),
    .push_data (angle_res),
    .en        (en),
    .stat      (bstat),
    .out_ch    (out_ch)
  );

  // skid entry only fills behind an occupied output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.skid_v |-> bstat.out_v)
    else $error("skid entry valid with empty output register");

  // a zero tangent leaves the chain as a zero angle
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl[NS].valid && ctl[NS].zero) |-> (angle_res == '0))
    else $error("zero input did not give zero angle");

  // clamp keeps every result within +/-pi/2
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.angle_out <= $signed(HALF_PI_Q28[ANG_W-1:0]))
                      && (out_ch.angle_out >= ANG_W'(-HALF_PI_Q28))))
    else $error("angle outside +/-pi/2");

  // reset empties the output side
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_ch.valid && en))
    else $error("output buffer not empty after reset");

endmodule

`default_nettype wire

// File: rtl/core/acv_cell.sv
// ----------------------------------------------------------------------------
// acv_cell - one vectoring CORDIC micro-rotation
// Rotates (x, y) by atan(2^-K) toward y = 0 and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module acv_cell
  import acv_pkg::*;
#(
  parameter int W = 48,
  parameter int K = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire ctl_t                  ctl_i,
  input  wire logic signed [W-1:0]   x_i,
  input  wire logic signed [W-1:0]   y_i,
  input  wire logic signed [Z_W-1:0] z_i,
  output ctl_t                       ctl_o,
  output logic signed [W-1:0]        x_o,
  output logic signed [W-1:0]        y_o,
  output logic signed [Z_W-1:0]      z_o
);

  localparam logic signed [Z_W-1:0] ANG = atan_rom(K);

  ctl_t                  ctl_r;
  logic signed [W-1:0]   x_r, x_nxt;
  logic signed [W-1:0]   y_r, y_nxt;
  logic signed [Z_W-1:0] z_r, z_nxt;
  logic signed [W-1:0]   dx, dy;

  always_comb begin
    dx = y_i >>> K;
    dy = x_i >>> K;
    if (y_i[W-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ANG;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

`default_nettype wire

// File: rtl/core/acv_outbuf.sv
// ----------------------------------------------------------------------------
// acv_outbuf - two-entry result buffer
// Output register plus skid entry; the pipeline stalls only once the skid
// entry is occupied, so the stall signal is a flop.
// ----------------------------------------------------------------------------
`default_nettype none

module acv_outbuf
  import acv_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire logic signed [ANG_W-1:0] push_data,
  output logic                         en,
  output buf_stat_t                    stat,
  acv_out_if.source                    out_ch
);

  logic                    out_v_r, skid_v_r;
  logic signed [ANG_W-1:0] out_d_r, skid_d_r;
  logic                    pop;

  assign pop = out_v_r && out_ch.ready;
  assign en  = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= push;
      end
    end else if (!out_v_r) begin
      out_v_r <= push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_d_r <= skid_v_r ? skid_d_r : push_data;
    end else if (!out_v_r) begin
      out_d_r <= push_data;
    end else if (push) begin
      skid_d_r <= push_data;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.angle_out = out_d_r;
  assign stat.out_v       = out_v_r;
  assign stat.skid_v      = skid_v_r;

endmodule

`default_nettype wire

// File: dv/tb_arctan_cordic_vectoring.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_arctan_cordic_vectoring - self-checking bench for the CORDIC arctangent
// Drives Q16.16 tangents into the core with random gaps and a long output
// stall, predicts each Q2.28 angle with a bit-true CORDIC model of its own,
// and compares every angle transfer in order against that prediction.
// ----------------------------------------------------------------------------

module tb_arctan_cordic_vectoring;
  import acv_pkg::*;

  // Core configuration as built (defaults of the top level)
  localparam int ITERS   = 23;
  localparam int XY_W    = 48;
  localparam int XY_FRAC = XY_W - 19;   // sign, 18 integer bits, rest fraction
  localparam int LATENCY = ((ITERS < ROM_DEPTH) ? ITERS : ROM_DEPTH) + 1;

  localparam int N_RANDOM   = 1430;
  localparam int IDLE_PCT   = 30;
  localparam int HOLD_START = 200;      // random transfer count at which output stalls
  localparam int HOLD_LEN   = 300;      // cycles of stalled output
  localparam int CALM_FROM  = 600;      // no idling on either side over this span
  localparam int CALM_TO    = 900;

  // atan(2^-k) * 2^32 rounded; from k = 11 on it is exactly 2^(32-k)
  localparam longint ATAN_STEP [ROM_DEPTH] = '{
    64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635,
    64'd268086748,  64'd134174063,  64'd67103403,   64'd33553749,
    64'd16777131,   64'd8388597,    64'd4194303,    64'd2097152,
    64'd1048576,    64'd524288,     64'd262144,     64'd131072,
    64'd65536,      64'd32768,      64'd16384,      64'd8192,
    64'd4096,       64'd2048,       64'd1024,       64'd512,
    64'd256,        64'd128,        64'd64,         64'd32,
    64'd16,         64'd8
  };

  // Directed vector: tangent plus, where it is obvious, the angle it must give
  typedef struct {
    logic signed [TAN_W-1:0] tangent;
    bit                      known;
    logic signed [ANG_W-1:0] angle;
  } tan_vec_t;

  localparam int N_DIRECTED = 20;
  tan_vec_t directed [N_DIRECTED] = '{
    '{32'sh0000_0000, 1'b1, 30'sd0},    // zero: the core forces the angle to 0
    '{32'sh0000_0000, 1'b1, 30'sd0},
    '{32'sh0000_0001, 1'b0, 30'sd0},    // smallest positive tangent
    '{32'shFFFF_FFFF, 1'b0, 30'sd0},    // smallest negative tangent
    '{32'sh7FFF_FFFF, 1'b0, 30'sd0},    // most positive: angle near +pi/2
    '{32'sh8000_0000, 1'b0, 30'sd0},    // most negative: angle near -pi/2
    '{32'sh0001_0000, 1'b0, 30'sd0},    // +1.0 -> pi/4
    '{32'shFFFF_0000, 1'b0, 30'sd0},    // -1.0 -> -pi/4
    '{32'sh0000_8000, 1'b0, 30'sd0},    // +0.5
    '{32'shFFFF_8000, 1'b0, 30'sd0},    // -0.5
    '{32'sh0000_FFFF, 1'b0, 30'sd0},
    '{32'sh7FFF_0000, 1'b0, 30'sd0},
    '{32'sh8001_0000, 1'b0, 30'sd0},
    '{32'sh5555_5555, 1'b0, 30'sd0},    // alternating bit patterns
    '{32'shAAAA_AAAA, 1'b0, 30'sd0},
    '{32'sh0001_BB68, 1'b0, 30'sd0},    // ~sqrt(3) -> ~pi/3
    '{32'sh0000_93CD, 1'b0, 30'sd0},    // ~1/sqrt(3) -> ~pi/6
    '{32'sh0100_0000, 1'b0, 30'sd0},
    '{32'shFF00_0000, 1'b0, 30'sd0},
    '{32'sh0000_0000, 1'b1, 30'sd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  acv_in_if  in_ch ();
  acv_out_if out_ch ();

  arctan_cordic_vectoring i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // Angles still owed by the core, oldest first
  logic signed [ANG_W-1:0] angle_due [$];

  int  n_sent, n_random_sent, n_checked, n_bad, n_zero, n_clamp;
  bit  calm;       // both sides run flat out
  bit  hold_off;   // output side refuses transfers

  // Bit-true vectoring CORDIC: x = 1, y = t, z = 0, steer on the sign of y
  function automatic logic signed [ANG_W-1:0] cordic_atan(
    input logic signed [TAN_W-1:0] tangent
  );
    logic signed [XY_W-1:0] x, y, dx, dy;
    logic signed [Z_W-1:0]  z, r, step;
    if (tangent == 0) return '0;
    x = '0;
    x[XY_FRAC] = 1'b1;
    y = {{(XY_W-TAN_W){tangent[TAN_W-1]}}, tangent};
    y = y <<< (XY_FRAC - 16);
    z = '0;
    for (int k = 0; k < ITERS && k < ROM_DEPTH; k++) begin
      dx   = y >>> k;   // floor shift, as the hardware truncates
      dy   = x >>> k;
      step = Z_W'(ATAN_STEP[k]);
      if (y < 0) begin
        x = x - dx;
        y = y + dy;
        z = z - step;
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + step;
      end
    end
    r = (z + 8) >>> 4;  // Q.32 -> Q.28, round half up
    if (r > HALF_PI_Q28) r = HALF_PI_Q28;
    if (r < -HALF_PI_Q28) r = -HALF_PI_Q28;
    return r[ANG_W-1:0];
  endfunction

  // Offer one tangent and wait for its transfer; the expected angle is
  // queued at the edge where the core takes it.
  task automatic send_tangent(input logic signed [TAN_W-1:0] tangent,
                              input bit known, input logic signed [ANG_W-1:0] angle);
    logic signed [ANG_W-1:0] want;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.tangent_in <= tangent;
    do @(posedge clk); while (!in_ch.ready);
    want = known ? angle : cordic_atan(tangent);
    angle_due.push_back(want);
    n_sent++;
    if (tangent == 0) n_zero++;
    if (want == HALF_PI_Q28[ANG_W-1:0] || want == -HALF_PI_Q28[ANG_W-1:0]) n_clamp++;
  endtask

  // Random tangents, weighted towards the interesting regions
  function automatic logic signed [TAN_W-1:0] pick_tangent();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40)      return $urandom();                                   // anywhere
    else if (sel < 70) return $signed($urandom_range(0, 524287)) - 262144;  // -4 <= t < 4
    else if (sel < 85) return $signed($urandom_range(0, 64)) - 32;          // few LSBs
    else if (sel < 95) begin                                                // near the rails
      if ($urandom_range(0, 1)) return 32'sh7FFF_FFFF - $urandom_range(0, 4095);
      else                      return 32'sh8000_0000 + $urandom_range(0, 4095);
    end
    else               return '0;
  endfunction

  // Sender, reset and end of run
  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.tangent_in <= '0;
    rst_n            <= 1'b0;
    calm             <= 1'b0;
    n_sent = 0; n_random_sent = 0; n_zero = 0; n_clamp = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_tangent(directed[i].tangent, directed[i].known, directed[i].angle);

    for (int i = 0; i < N_RANDOM; i++) begin
      calm <= (i >= CALM_FROM && i < CALM_TO);
      send_tangent(pick_tangent(), 1'b0, '0);
      n_random_sent++;
    end
    in_ch.valid <= 1'b0;
    calm        <= 1'b0;

    while (angle_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Sent %0d tangents (%0d directed, %0d zero, %0d at the pi/2 clamp).",
             n_sent, N_DIRECTED, n_zero, n_clamp);
    $display("Checked %0d angle transfers, %0d mismatches, one long output stall.",
             n_checked, n_bad);
    if (n_bad == 0 && angle_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Long output stall once traffic is flowing, so the chain and skid fill
  // and the input side has to back off.
  initial begin
    hold_off <= 1'b0;
    while (n_random_sent < HOLD_START) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Receiver: checks each transfer against the oldest expectation
  initial begin
    logic signed [ANG_W-1:0] want;
    out_ch.ready <= 1'b0;
    n_checked = 0;
    n_bad     = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (angle_due.size() == 0) begin
          $display("%0t: angle %0d transferred with none outstanding",
                   $realtime, out_ch.angle_out);
          n_bad++;
        end else begin
          want = angle_due.pop_front();
          n_checked++;
          if (out_ch.angle_out !== want) begin
            $display("%0t: angle_out mismatch, expected %0d, got %0d",
                     $realtime, want, out_ch.angle_out);
            n_bad++;
          end
        end
      end
      if (hold_off)  out_ch.ready <= 1'b0;
      else if (calm) out_ch.ready <= 1'b1;
      else           out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("Timed out with %0d angles outstanding", angle_due.size());
    $display("FAIL");
    $finish;
  end

endmodule
